FILE: sv/assert_macros.svh
// Assertion macros used by the top level of the HSV converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/hsv_pkg.sv
// Shared types and constants of the RGB to HSV pixel converter.
`default_nettype none

package hsv_pkg;

    localparam int PIX_W        = 8;
    localparam int FRONT_STAGES = 3;
    localparam int HUE_DEN_W    = 11;   // 6 * d, d up to 255
    localparam int HUE_NUM_W    = 19;   // 255 * t, t below 6 * d
    localparam int SAT_NUM_W    = 16;   // 255 * d

    // Sector holding the maximum; red wins ties over green, green over blue.
    typedef enum logic [2:0] {
        SEC_RED   = 3'b001,
        SEC_GREEN = 3'b010,
        SEC_BLUE  = 3'b100
    } sector_t;

    typedef struct packed {
        logic [HUE_NUM_W-1:0] hue_num;
        logic [HUE_DEN_W-1:0] hue_den;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [PIX_W-1:0]     sat_den;
        logic [PIX_W-1:0]     val;
    } prep_t;

endpackage

`default_nettype wire

FILE: sv/hsv_front.sv
// Front stages: input capture, max/min and sector, dividend and divisor setup.
`default_nettype none

module hsv_front (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic [hsv_pkg::PIX_W-1:0] red_in,
    input  wire logic [hsv_pkg::PIX_W-1:0] green_in,
    input  wire logic [hsv_pkg::PIX_W-1:0] blue_in,
    output hsv_pkg::prep_t                 prep
);
    import hsv_pkg::*;

    // stage 1: captured samples
    logic [PIX_W-1:0] r_reg, g_reg, b_reg;

    // stage 2: classification
    logic [PIX_W-1:0] mx_reg, mx_next;
    logic [PIX_W-1:0] d_reg, d_next;
    sector_t          sec_reg, sec_next;
    logic signed [PIX_W:0] diff_reg, diff_next;
    logic [PIX_W-1:0] mn;

    // stage 3: division operands
    prep_t prep_reg, prep_next;
    logic [HUE_DEN_W-1:0] six_d, off;
    logic signed [HUE_DEN_W:0] t_wide;
    logic [HUE_DEN_W-1:0] t;

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= red_in;
            g_reg <= green_in;
            b_reg <= blue_in;
        end
    end

    always_comb begin
        if (r_reg >= g_reg && r_reg >= b_reg) begin
            sec_next  = SEC_RED;
            mx_next   = r_reg;
            diff_next = $signed({1'b0, g_reg}) - $signed({1'b0, b_reg});
        end else if (g_reg >= b_reg) begin
            sec_next  = SEC_GREEN;
            mx_next   = g_reg;
            diff_next = $signed({1'b0, b_reg}) - $signed({1'b0, r_reg});
        end else begin
            sec_next  = SEC_BLUE;
            mx_next   = b_reg;
            diff_next = $signed({1'b0, r_reg}) - $signed({1'b0, g_reg});
        end
        mn = r_reg;
        if (g_reg < mn) mn = g_reg;
        if (b_reg < mn) mn = b_reg;
        d_next = mx_next - mn;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg   <= mx_next;
            d_reg    <= d_next;
            sec_reg  <= sec_next;
            diff_reg <= diff_next;
        end
    end

    // Hue numerator t = sector offset + signed difference; red wraps by 6d when negative.
    always_comb begin
        six_d = HUE_DEN_W'({d_reg, 2'b00}) + HUE_DEN_W'({d_reg, 1'b0});
        unique case (sec_reg)
            SEC_RED:   off = diff_reg[PIX_W] ? six_d : '0;
            SEC_GREEN: off = HUE_DEN_W'({d_reg, 1'b0});
            SEC_BLUE:  off = HUE_DEN_W'({d_reg, 2'b00});
            default:   off = '0;
        endcase
        t_wide = $signed({1'b0, off})
               + $signed({{(HUE_DEN_W-PIX_W){diff_reg[PIX_W]}}, diff_reg});
        t = t_wide[HUE_DEN_W-1:0];

        prep_next.val     = mx_reg;
        prep_next.sat_num = SAT_NUM_W'({d_reg, 8'b0}) - SAT_NUM_W'(d_reg);
        prep_next.sat_den = (mx_reg == '0) ? PIX_W'(1) : mx_reg;
        // grey pixel: force a zero quotient and keep the divisor nonzero
        if (d_reg == '0) begin
            prep_next.hue_num = '0;
            prep_next.hue_den = HUE_DEN_W'(1);
        end else begin
            prep_next.hue_num = HUE_NUM_W'({t, 8'b0}) - HUE_NUM_W'(t);
            prep_next.hue_den = six_d;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_reg <= prep_next;
        end
    end

    assign prep = prep_reg;

endmodule

`default_nettype wire

FILE: sv/hsv_div.sv
// Pipelined restoring divider, STEP_BITS quotient bits per register stage.
`default_nettype none

module hsv_div #(
    parameter int NUM_W     = 19,
    parameter int DEN_W     = 11,
    parameter int Q_W       = 8,
    parameter int STEP_BITS = 2
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [Q_W-1:0]   quo
);
    localparam int STAGES = Q_W / STEP_BITS;
    localparam int CMP_W  = NUM_W + Q_W;

    // The caller guarantees num < den * 2**Q_W, so the remainder fits NUM_W bits.
    logic [NUM_W-1:0] rem_reg [STAGES];
    logic [DEN_W-1:0] den_reg [STAGES];
    logic [Q_W-1:0]   quo_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [NUM_W-1:0] rem_src;
        logic [DEN_W-1:0] den_src;
        logic [Q_W-1:0]   quo_src;
        logic [CMP_W-1:0] rem_w;
        logic [CMP_W-1:0] shifted;
        logic [Q_W-1:0]   quo_w;

        if (s == 0) begin : g_first
            assign rem_src = num;
            assign den_src = den;
            assign quo_src = '0;
        end else begin : g_rest
            assign rem_src = rem_reg[s-1];
            assign den_src = den_reg[s-1];
            assign quo_src = quo_reg[s-1];
        end

        always_comb begin
            rem_w   = CMP_W'(rem_src);
            quo_w   = quo_src;
            shifted = '0;
            for (int k = 0; k < STEP_BITS; k++) begin
                shifted = CMP_W'(den_src) << (Q_W - 1 - s * STEP_BITS - k);
                if (rem_w >= shifted) begin
                    rem_w = rem_w - shifted;
                    quo_w[Q_W - 1 - s * STEP_BITS - k] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_w[NUM_W-1:0];
                den_reg[s] <= den_src;
                quo_reg[s] <= quo_w;
            end
        end
    end

    assign quo = quo_reg[STAGES-1];

endmodule

`default_nettype wire

FILE: sv/rgb_to_hsv_pixel.sv
// Usage: RGB to HSV pixel converter, 8 bits per channel, fully pipelined.
//
// Input stream s_*: s_tdata carries red, green, blue (red in the low byte).
// Result stream m_*: m_tdata carries hue, saturation, value (hue low byte).
// Value is the channel maximum, saturation floor(255*(max-min)/max) with
// zero for black, hue floor(255*H/360) with zero for grey pixels.
//
// Pipeline: 3 + 8/DIV_STEP_BITS register stages (7 by default): capture,
// max/min, operand setup, then the two restoring dividers that resolve
// DIV_STEP_BITS quotient bits per stage. m_tvalid is the valid bit of the
// last of these stages.
// Throughput: one pixel per clock while m_tready is high.
// Stall: with m_tready low and a result waiting, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated. Empty slots never stall.
// Reset (aresetn low, synchronous) clears all valid bits and holds s_tready
// low; data registers keep whatever they held and are ignored until refilled.
`default_nettype none

module rgb_to_hsv_pixel #(
    parameter int DIV_STEP_BITS = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata    // hue_out[7:0], sat_out[15:8], val_out[23:16]
);
    import hsv_pkg::*;
    `include "assert_macros.svh"

    localparam int DIV_STAGES = PIX_W / DIV_STEP_BITS;
    localparam int LAT        = FRONT_STAGES + DIV_STAGES;

    logic             en;
    logic             vld_reg [LAT];
    logic [PIX_W-1:0] val_reg [DIV_STAGES];
    prep_t            prep;
    logic [PIX_W-1:0] hue_q, sat_q;

    // advance everything unless a finished item is waiting on the receiver
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en && aresetn;

    hsv_front u_front (
        .aclk     (aclk),
        .en       (en),
        .red_in   (s_tdata[7:0]),
        .green_in (s_tdata[15:8]),
        .blue_in  (s_tdata[23:16]),
        .prep     (prep)
    );

    hsv_div #(
        .NUM_W     (HUE_NUM_W),
        .DEN_W     (HUE_DEN_W),
        .Q_W       (PIX_W),
        .STEP_BITS (DIV_STEP_BITS)
    ) u_hue_div (
        .aclk (aclk),
        .en   (en),
        .num  (prep.hue_num),
        .den  (prep.hue_den),
        .quo  (hue_q)
    );

    hsv_div #(
        .NUM_W     (SAT_NUM_W),
        .DEN_W     (PIX_W),
        .Q_W       (PIX_W),
        .STEP_BITS (DIV_STEP_BITS)
    ) u_sat_div (
        .aclk (aclk),
        .en   (en),
        .num  (prep.sat_num),
        .den  (prep.sat_den),
        .quo  (sat_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // carry value alongside the dividers
    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg[0] <= prep.val;
            for (int i = 1; i < DIV_STAGES; i++) begin
                val_reg[i] <= val_reg[i-1];
            end
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {val_reg[DIV_STAGES-1], sat_q, hue_q};

    `ASSERT_IMPLIES(a_black_sat_zero, aclk, aresetn,
        m_tvalid && m_tdata[23:16] == 8'd0, m_tdata[15:8] == 8'd0,
        "saturation nonzero for a black pixel")
    `ASSERT_IMPLIES(a_hue_range, aclk, aresetn,
        m_tvalid, m_tdata[7:0] != 8'd255,
        "hue out of range")
    `ASSERT_IMPLIES(a_grey_hue_zero, aclk, aresetn,
        m_tvalid && m_tdata[15:8] == 8'd0, m_tdata[7:0] == 8'd0,
        "hue nonzero for a grey pixel")
    `ASSERT_NEXT(a_accept_enters, aclk, aresetn,
        s_tvalid && s_tready, vld_reg[0],
        "accepted item did not enter the pipeline")

endmodule

`default_nettype wire
